### sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared widths, angle constants, arctangent table and the quadrant flags of
// the cartesian to polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int ROTATION_STEPS_DEF = 16;
    localparam int MAX_STEPS          = 32;
    localparam int PRESCALE           = 14;
    localparam int RADIUS_WIDTH       = 16;
    localparam int ANGLE_WIDTH        = 17;
    localparam int Z_WIDTH            = 25;
    localparam int FULL_WIDTH         = 25;
    localparam int ANGLE_FRAC         = 8;
    localparam int ANGLE_HALF_LSB     = 128;
    localparam int DEG90              = 5898240;
    localparam int DEG180             = 11796480;
    localparam int DEG360             = 23592960;
    localparam int ANGLE_MOD          = 92160;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic nonzero;
    } t_quad;

    // round(atan(2^-i) in degrees * 65536)
    function automatic logic [Z_WIDTH-1:0] atan_deg16(input int idx);
        logic [Z_WIDTH-1:0] v;
        case (idx)
            0:  v = Z_WIDTH'(2949120);
            1:  v = Z_WIDTH'(1740967);
            2:  v = Z_WIDTH'(919879);
            3:  v = Z_WIDTH'(466945);
            4:  v = Z_WIDTH'(234379);
            5:  v = Z_WIDTH'(117304);
            6:  v = Z_WIDTH'(58666);
            7:  v = Z_WIDTH'(29335);
            8:  v = Z_WIDTH'(14668);
            9:  v = Z_WIDTH'(7334);
            10: v = Z_WIDTH'(3667);
            11: v = Z_WIDTH'(1833);
            12: v = Z_WIDTH'(917);
            13: v = Z_WIDTH'(458);
            14: v = Z_WIDTH'(229);
            15: v = Z_WIDTH'(115);
            16: v = Z_WIDTH'(57);
            17: v = Z_WIDTH'(29);
            18: v = Z_WIDTH'(14);
            19: v = Z_WIDTH'(7);
            20: v = Z_WIDTH'(4);
            21: v = Z_WIDTH'(2);
            22: v = Z_WIDTH'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/c2p_if.sv
// ----------------------------------------------------------------------------
// c2p interfaces
// Valid/ready channels for the point beat and the polar result beat.
// ----------------------------------------------------------------------------
interface c2p_pt_if #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_value;
    logic signed [COORD_WIDTH-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

interface c2p_pol_if;
    logic                                 valid;
    logic                                 ready;
    logic [c2p_pkg::RADIUS_WIDTH-1:0]     radius;
    logic [c2p_pkg::ANGLE_WIDTH-1:0]      angle;

    modport source (output valid, output radius, output angle, input ready);
    modport sink   (input valid, input radius, input angle, output ready);
endinterface

### sv/c2p_sqrt.sv
// ----------------------------------------------------------------------------
// c2p_sqrt
// Radius pipeline: squares, sum, one root bit per stage, then rounding to
// nearest and saturation. Output is delayed to the common pipeline depth.
// ----------------------------------------------------------------------------
module c2p_sqrt #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int LAT         = COORD_WIDTH + 3
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [COORD_WIDTH-1:0]           i_ax,
    input  logic [COORD_WIDTH-1:0]           i_ay,
    output logic [c2p_pkg::RADIUS_WIDTH-1:0] o_radius
);

    localparam int SW  = 2 * COORD_WIDTH;
    localparam int NB  = COORD_WIDTH;
    localparam int RMW = NB + 3;
    localparam int RW  = c2p_pkg::RADIUS_WIDTH;
    localparam int OWN = NB + 3;
    localparam int CW2 = (NB + 1 > RW) ? NB + 1 : RW;

    logic [SW-1:0]  r_sqx;
    logic [SW-1:0]  r_sqy;
    logic [SW-1:0]  r_sv   [0:NB];
    logic [RMW-1:0] r_rem  [0:NB];
    logic [NB-1:0]  r_root [0:NB];
    logic [RW-1:0]  r_out  [OWN:LAT];

    logic           up;
    logic [NB:0]    rr;
    logic           sat;

    // squares, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx    <= {{COORD_WIDTH{1'b0}}, i_ax} * {{COORD_WIDTH{1'b0}}, i_ax};
            r_sqy    <= {{COORD_WIDTH{1'b0}}, i_ay} * {{COORD_WIDTH{1'b0}}, i_ay};
            r_sv[0]   <= r_sqx + r_sqy;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < NB; k++) begin : g_digit
        logic [RMW-1:0] remsh;
        logic [RMW-1:0] trial;
        logic [RMW-1:0] n_rem;
        logic [NB-1:0]  n_root;

        always_comb begin
            remsh = {r_rem[k][RMW-3:0], r_sv[k][SW-1 -: 2]};
            trial = RMW'({r_root[k], 2'b01});
            if (remsh >= trial) begin
                n_rem  = remsh - trial;
                n_root = {r_root[k][NB-2:0], 1'b1};
            end else begin
                n_rem  = remsh;
                n_root = {r_root[k][NB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[k+1]   <= r_sv[k] << 2;
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
            end
        end
    end

    // round to nearest, saturate
    always_comb begin
        up  = r_rem[NB] > RMW'(r_root[NB]);
        rr  = (NB+1)'(r_root[NB]) + (NB+1)'(up);
        sat = CW2'(rr) > CW2'({RW{1'b1}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out[OWN] <= sat ? {RW{1'b1}} : RW'(rr);
        end
    end

    for (genvar j = OWN + 1; j <= LAT; j++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_out[j] <= r_out[j-1];
            end
        end
    end

    assign o_radius = r_out[LAT];

endmodule

### sv/c2p_cordic.sv
// ----------------------------------------------------------------------------
// c2p_cordic
// Angle pipeline: one vectoring rotation per stage on the magnitudes, then
// clamp and quadrant fold, then rounding to 1/256 degree with wrap at 360.
// ----------------------------------------------------------------------------
module c2p_cordic #(
    parameter int COORD_WIDTH    = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STEPS = c2p_pkg::ROTATION_STEPS_DEF,
    parameter int LAT            = ROTATION_STEPS + 2
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [COORD_WIDTH-1:0]          i_ax,
    input  logic [COORD_WIDTH-1:0]          i_ay,
    input  c2p_pkg::t_quad                  i_quad,
    output logic [c2p_pkg::ANGLE_WIDTH-1:0] o_angle
);

    localparam int STEPS = (ROTATION_STEPS > c2p_pkg::MAX_STEPS) ?
                           c2p_pkg::MAX_STEPS : ROTATION_STEPS;
    localparam int CXW   = COORD_WIDTH + c2p_pkg::PRESCALE + 3;
    localparam int ZW    = c2p_pkg::Z_WIDTH;
    localparam int FW    = c2p_pkg::FULL_WIDTH;
    localparam int AW    = c2p_pkg::ANGLE_WIDTH;
    localparam int OWN   = STEPS + 2;

    localparam logic signed [ZW-1:0] Z_DEG90   = ZW'(c2p_pkg::DEG90);
    localparam logic [FW-1:0]        F_DEG90   = FW'(c2p_pkg::DEG90);
    localparam logic [FW-1:0]        F_DEG180  = FW'(c2p_pkg::DEG180);
    localparam logic [FW-1:0]        F_DEG360  = FW'(c2p_pkg::DEG360);
    localparam logic [FW-1:0]        F_HALF    = FW'(c2p_pkg::ANGLE_HALF_LSB);
    localparam logic [AW-1:0]        A_MOD     = AW'(c2p_pkg::ANGLE_MOD);

    logic signed [CXW-1:0] r_cx [0:STEPS-1];
    logic signed [CXW-1:0] r_cy [0:STEPS-1];
    logic signed [ZW-1:0]  r_z  [0:STEPS-1];
    c2p_pkg::t_quad        r_q  [0:STEPS-1];

    logic [FW-1:0]         r_full;
    c2p_pkg::t_quad        r_qf;
    logic [AW-1:0]         r_out [OWN:LAT];

    logic [FW-1:0]         t;
    logic [FW-1:0]         n_full;
    logic [FW-1:0]         rnd;
    logic [AW-1:0]         a;
    logic [AW-1:0]         n_angle;

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        logic signed [CXW-1:0] cx_in;
        logic signed [CXW-1:0] cy_in;
        logic signed [ZW-1:0]  z_in;
        c2p_pkg::t_quad        q_in;
        logic signed [CXW-1:0] dx;
        logic signed [CXW-1:0] dy;
        logic signed [ZW-1:0]  at;

        if (k == 0) begin : g_first
            assign cx_in = $signed({3'b000, i_ax, {c2p_pkg::PRESCALE{1'b0}}});
            assign cy_in = $signed({3'b000, i_ay, {c2p_pkg::PRESCALE{1'b0}}});
            assign z_in  = '0;
            assign q_in  = i_quad;
        end else begin : g_next
            assign cx_in = r_cx[k-1];
            assign cy_in = r_cy[k-1];
            assign z_in  = r_z[k-1];
            assign q_in  = r_q[k-1];
        end

        assign dx = cy_in >>> k;
        assign dy = cx_in >>> k;
        assign at = $signed(c2p_pkg::atan_deg16(k));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (cy_in > 0) begin
                    r_cx[k] <= cx_in + dx;
                    r_cy[k] <= cy_in - dy;
                    r_z[k]  <= z_in + at;
                end else begin
                    r_cx[k] <= cx_in - dx;
                    r_cy[k] <= cy_in + dy;
                    r_z[k]  <= z_in - at;
                end
                r_q[k] <= q_in;
            end
        end
    end

    // clamp to the first quadrant, then fold by quadrant
    always_comb begin
        if (r_z[STEPS-1] < 0) begin
            t = '0;
        end else if (r_z[STEPS-1] > Z_DEG90) begin
            t = F_DEG90;
        end else begin
            t = FW'(r_z[STEPS-1]);
        end
        case ({r_q[STEPS-1].x_neg, r_q[STEPS-1].y_neg})
            2'b00:   n_full = t;
            2'b01:   n_full = F_DEG360 - t;
            2'b10:   n_full = F_DEG180 - t;
            default: n_full = F_DEG180 + t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_full <= n_full;
            r_qf   <= r_q[STEPS-1];
        end
    end

    // round to 1/256 degree, wrap at 360, angle 0 for the origin
    always_comb begin
        rnd = r_full + F_HALF;
        a   = rnd[FW-1:c2p_pkg::ANGLE_FRAC];
        if (!r_qf.nonzero) begin
            n_angle = '0;
        end else if (a >= A_MOD) begin
            n_angle = a - A_MOD;
        end else begin
            n_angle = a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out[OWN] <= n_angle;
        end
    end

    for (genvar j = OWN + 1; j <= LAT; j++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_out[j] <= r_out[j-1];
            end
        end
    end

    assign o_angle = r_out[LAT];

endmodule

### sv/cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Converts a signed (x, y) point to a rounded radius and an angle in
// 1/256 degree over [0, 360).
// ----------------------------------------------------------------------------
// One point is taken per cycle while the output buffer is not full, and
// results leave in the order points came in. A point passes an input
// register, the pipeline, whose depth is set by the longer of the
// square-root chain (one root bit per stage) and the rotation chain (one
// rotation per stage), and a two-beat output buffer. The buffer lets the
// pipeline keep moving while a result waits; input ready drops only once
// that buffer is full. The origin gives radius 0 and angle 0.
// ----------------------------------------------------------------------------
module cartesian_to_polar #(
    parameter int COORD_WIDTH    = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STEPS = c2p_pkg::ROTATION_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    c2p_pt_if.sink           i_pt,
    c2p_pol_if.source        o_pol
);

    localparam int STEPS = (ROTATION_STEPS > c2p_pkg::MAX_STEPS) ?
                           c2p_pkg::MAX_STEPS : ROTATION_STEPS;
    localparam int LAT   = (COORD_WIDTH + 3 > STEPS + 2) ? COORD_WIDTH + 3 : STEPS + 2;
    localparam int RW    = c2p_pkg::RADIUS_WIDTH;
    localparam int AW    = c2p_pkg::ANGLE_WIDTH;

    logic                          en;
    logic [LAT:0]                  r_vld;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0]        r_ax;
    logic [COORD_WIDTH-1:0]        r_ay;
    c2p_pkg::t_quad                r_quad;
    logic [RW-1:0]                 radius;
    logic [AW-1:0]                 angle;

    logic [RW-1:0]                 r_buf_rad [0:1];
    logic [AW-1:0]                 r_buf_ang [0:1];
    logic                          r_wp;
    logic                          r_rp;
    logic [1:0]                    r_cnt;
    logic [1:0]                    n_cnt;
    logic                          push;
    logic                          pop;

    assign en         = (r_cnt != 2'd2);
    assign i_pt.ready = en;
    assign x          = i_pt.x_value;
    assign y          = i_pt.y_value;

    // input register: magnitudes and quadrant
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax           <= x[COORD_WIDTH-1] ? COORD_WIDTH'(-x) : COORD_WIDTH'(x);
            r_ay           <= y[COORD_WIDTH-1] ? COORD_WIDTH'(-y) : COORD_WIDTH'(y);
            r_quad.x_neg   <= x[COORD_WIDTH-1];
            r_quad.y_neg   <= y[COORD_WIDTH-1];
            r_quad.nonzero <= (x != '0) || (y != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:0], i_pt.valid};
        end
    end

    c2p_sqrt #(
        .COORD_WIDTH (COORD_WIDTH),
        .LAT         (LAT)
    ) u_sqrt (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_ax     (r_ax),
        .i_ay     (r_ay),
        .o_radius (radius)
    );

    c2p_cordic #(
        .COORD_WIDTH    (COORD_WIDTH),
        .ROTATION_STEPS (ROTATION_STEPS),
        .LAT            (LAT)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_quad  (r_quad),
        .o_angle (angle)
    );

    // two-beat output buffer
    assign push = en && r_vld[LAT];
    assign pop  = o_pol.valid && o_pol.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf_rad[r_wp] <= radius;
            r_buf_ang[r_wp] <= angle;
        end
    end

    assign o_pol.valid  = (r_cnt != 2'd0);
    assign o_pol.radius = r_buf_rad[r_rp];
    assign o_pol.angle  = r_buf_ang[r_rp];

    a_origin_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pol.valid && (o_pol.radius == '0) |-> (o_pol.angle == '0))
        else $error("zero radius with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pol.valid |-> (o_pol.angle < AW'(c2p_pkg::ANGLE_MOD)))
        else $error("angle beyond 360 degrees");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> o_pol.valid && (r_cnt == 2'd2))
        else $error("input stalled without a full output buffer");

    a_buf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !o_pol.ready |=> (r_cnt == 2'd2))
        else $error("output buffer lost a beat");

endmodule
